@@ src/dsv_pkg.sv @@
package dsv_pkg;

	localparam int SAMPLE_RATE     = 48000;
	localparam int SINE_TABLE_BITS = 10;
	localparam int PHASE_BITS      = 32;

	localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
	localparam int QUARTER_W = SINE_TABLE_BITS - 1;

	localparam int ENV_W    = 16;
	localparam int LEVEL_W  = 16;
	localparam int SIN_W    = 15;
	localparam int SAMPLE_W = 16;
	localparam int NOTE_W   = 7;
	localparam int VEL_W    = 7;
	localparam int NOTES    = 1 << NOTE_W;
	localparam int VELS     = 1 << VEL_W;

	localparam int MUL_A_W = SIN_W + LEVEL_W;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [63:0] HALF_PI_Q30    = 64'd1686629713;
	localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
	localparam logic [63:0] SAMPLE_RATE_Q16 = 64'(SAMPLE_RATE) << 16;

	localparam logic [ENV_W-1:0] ENV_ONE       = 16'd32768;
	localparam logic [15:0]      DECAY_RESET   = 16'd32440;
	localparam logic [15:0]      STOP_RESET    = 16'd164;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_NOTE_ON  = 2'd1,
		REQ_NOTE_OFF = 2'd2,
		REQ_NOTE_CUT = 2'd3
	} req_t;

	typedef enum logic {
		REG_DECAY = 1'b0,
		REG_STOP  = 1'b1
	} reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LVL,
		ST_MUL_ENV,
		ST_MUL_DEC,
		ST_UPDATE,
		ST_WAIT
	} state_t;

	typedef struct packed {
		logic [15:0] decay_factor;
		logic [15:0] stop_level;
	} cfg_t;

	typedef logic [SIN_W-1:0]      sine_rom_t  [0:QUARTER];
	typedef logic [PHASE_BITS-1:0] step_rom_t  [0:NOTES-1];
	typedef logic [LEVEL_W-1:0]    level_rom_t [0:VELS-1];
	typedef logic [31:0]           octave_t    [0:11];

	// notes 120..131 in Q16.16 Hz
	localparam octave_t TOP_OCTAVE_Q16 = '{
		32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
		32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
		32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
	};

	// quarter-wave sine magnitude, Q1.15, taylor series to degree 11
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] s;
		logic [63:0] v;
		for (int q = 0; q <= QUARTER; q++) begin
			th = (64'(q) * HALF_PI_Q30) >> (SINE_TABLE_BITS - 2);
			t2 = (th * th) >> 30;
			s = ONE_Q30;
			s = ONE_Q30 - ((t2 * s) >> 30) / 64'd110;
			s = ONE_Q30 - ((t2 * s) >> 30) / 64'd72;
			s = ONE_Q30 - ((t2 * s) >> 30) / 64'd42;
			s = ONE_Q30 - ((t2 * s) >> 30) / 64'd20;
			s = ONE_Q30 - ((t2 * s) >> 30) / 64'd6;
			v = (th * s) >> 30;
			v = (v + (64'd1 << 14)) >> 15;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[q] = v[SIN_W-1:0];
		end
		return rom;
	endfunction

	// phase step per note, rounded half up
	function automatic step_rom_t build_step_rom();
		step_rom_t rom;
		logic [63:0] num;
		logic [63:0] half;
		logic [63:0] tmp;
		int oct;
		int k;
		for (int n = 0; n < NOTES; n++) begin
			oct = n / 12;
			k = n % 12;
			num = 64'(TOP_OCTAVE_Q16[k]) << PHASE_BITS;
			half = (SAMPLE_RATE_Q16 << (10 - oct)) >> 1;
			tmp = ((num + half) / SAMPLE_RATE_Q16) >> (10 - oct);
			rom[n] = tmp[PHASE_BITS-1:0];
		end
		return rom;
	endfunction

	// velocity * 3 / 127 in Q2.14
	function automatic level_rom_t build_level_rom();
		level_rom_t rom;
		logic [31:0] tmp;
		for (int v = 0; v < VELS; v++) begin
			tmp = (32'(v) * 32'd49152 + 32'd63) / 32'd127;
			rom[v] = tmp[LEVEL_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t  SINE_ROM  = build_sine_rom();
	localparam step_rom_t  STEP_ROM  = build_step_rom();
	localparam level_rom_t LEVEL_ROM = build_level_rom();

endpackage

@@ src/dsv_mul.sv @@
module dsv_mul (
	input  logic                         clk,
	input  logic [dsv_pkg::MUL_A_W-1:0]  a,
	input  logic [dsv_pkg::MUL_B_W-1:0]  b,
	output logic [dsv_pkg::MUL_P_W-1:0]  p
);
	import dsv_pkg::*;

	logic [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= MUL_P_W'(a) * MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

@@ src/dsv_core.sv @@
module dsv_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dsv_pkg::cfg_t                 cfg,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [1:0]                    req_type,
	input  logic [dsv_pkg::NOTE_W-1:0]    note,
	input  logic [dsv_pkg::VEL_W-1:0]     velocity,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [dsv_pkg::SAMPLE_W-1:0]  sample,
	output logic                          voice_active
);
	import dsv_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [PHASE_BITS-1:0] phase_q;
	logic [PHASE_BITS-1:0] step_q;
	logic [LEVEL_W-1:0]    level_q;
	logic [ENV_W-1:0]      env_q;
	logic                  active_q;

	logic [SIN_W-1:0]    sin_mag_q;
	logic                sin_neg_q;
	logic [SAMPLE_W-1:0] pend_sample_q;
	logic                pend_active_q;

	logic                m_valid_q;
	logic [SAMPLE_W-1:0] out_sample_q;
	logic                out_active_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;

	logic accept;
	logic out_free;
	logic load_out;

	logic [SINE_TABLE_BITS-1:0] idx;
	logic [1:0]                 quad;
	logic [QUARTER_W-1:0]       r_ext;
	logic [QUARTER_W-1:0]       q_idx;

	logic [MUL_P_W:0]    rnd;
	logic [16:0]         r17;
	logic [16:0]         neg17;
	logic [SAMPLE_W-1:0] sample_val;
	logic [16:0]         e17;
	logic [ENV_W-1:0]    env_new;

	dsv_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	// sine lookup by quarter-wave folding
	assign idx   = phase_q[PHASE_BITS-1 -: SINE_TABLE_BITS];
	assign quad  = idx[SINE_TABLE_BITS-1 -: 2];
	assign r_ext = {1'b0, idx[SINE_TABLE_BITS-3:0]};
	assign q_idx = quad[0] ? (QUARTER_W'(QUARTER) - r_ext) : r_ext;

	// round Q44 product to Q2.13, saturate with sign
	assign rnd   = {1'b0, mul_p} + ((MUL_P_W+1)'(1) << 30);
	assign r17   = rnd[47:31];
	assign neg17 = 17'h10000 - r17;
	always_comb begin
		if (sin_neg_q) begin
			sample_val = (r17 > 17'd32768) ? 16'h8000 : neg17[15:0];
		end else begin
			sample_val = (r17 > 17'd32767) ? 16'h7fff : r17[15:0];
		end
	end

	// envelope decay
	assign e17     = mul_p[31:15];
	assign env_new = e17[16] ? 16'hffff : e17[15:0];

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_comb begin
		s_tready = 1'b0;
		load_out = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MUL_LVL: begin
				mul_a = MUL_A_W'(sin_mag_q);
				mul_b = level_q;
			end
			ST_MUL_ENV: begin
				mul_a = mul_p[MUL_A_W-1:0];
				mul_b = env_q;
			end
			ST_MUL_DEC: begin
				mul_a = MUL_A_W'(env_q);
				mul_b = cfg.decay_factor;
			end
			ST_UPDATE: begin
				load_out = out_free;
			end
			ST_WAIT: begin
				load_out = out_free;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_type == REQ_TICK) begin
					state_d = active_q ? ST_MUL_LVL : ST_WAIT;
				end
			end
			ST_MUL_LVL: state_d = ST_MUL_ENV;
			ST_MUL_ENV: state_d = ST_MUL_DEC;
			ST_MUL_DEC: state_d = ST_UPDATE;
			ST_UPDATE:  state_d = load_out ? ST_IDLE : ST_WAIT;
			ST_WAIT: begin
				if (load_out) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= '0;
			step_q   <= '0;
			level_q  <= '0;
			env_q    <= '0;
			active_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (req_type)
					REQ_NOTE_ON: begin
						phase_q  <= '0;
						step_q   <= STEP_ROM[note];
						level_q  <= LEVEL_ROM[velocity];
						env_q    <= ENV_ONE;
						active_q <= 1'b1;
					end
					REQ_NOTE_CUT: begin
						step_q   <= '0;
						active_q <= 1'b0;
					end
					REQ_TICK, REQ_NOTE_OFF: begin
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_UPDATE) begin
				phase_q <= phase_q + step_q;
				env_q   <= env_new;
				if (env_new <= cfg.stop_level) begin
					active_q <= 1'b0;
					step_q   <= '0;
				end
			end
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (accept && req_type == REQ_TICK) begin
			sin_mag_q     <= SINE_ROM[q_idx];
			sin_neg_q     <= quad[1];
			pend_active_q <= active_q;
			pend_sample_q <= '0;
		end
		if (state_q == ST_MUL_DEC) begin
			pend_sample_q <= sample_val;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_sample_q <= pend_sample_q;
			out_active_q <= pend_active_q;
		end
	end

	assign m_tvalid     = m_valid_q;
	assign sample       = out_sample_q;
	assign voice_active = out_active_q;

endmodule

@@ src/decaying_sine_voice.sv @@
// tick while sounding: states MUL_LVL, MUL_ENV, MUL_DEC, UPDATE; ready when result is loaded
// tick while silent: goes to WAIT, zero sample when loaded; note on/off requests keep it idle
// one shared 31x16 multiplier carries level, envelope and decay products in turn
// a result waiting in the output register does not block the next request
// reset (arst_n low, asynchronous): voice silent, state zero, registers at defaults
module decaying_sine_voice (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [15:0]                  s_tdata,  // note[6:0], velocity[13:7], zero pad
	input  logic [1:0]                   s_tuser,  // req_type[1:0]
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [15:0]                  m_tdata,  // sample[15:0]
	output logic                         m_tuser,  // voice_active
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsv_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsv_pkg::PDATA_W-1:0]  pwdata,
	output logic [dsv_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import dsv_pkg::*;

	logic [15:0] decay_q;
	logic [15:0] stop_q;
	logic        reg_sel;
	logic        wr_en;
	cfg_t        cfg;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RESET;
			stop_q  <= STOP_RESET;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_DECAY: decay_q <= pwdata[15:0];
				REG_STOP:  stop_q  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_DECAY: prdata = PDATA_W'(decay_q);
			REG_STOP:  prdata = PDATA_W'(stop_q);
			default:   prdata = '0;
		endcase
	end

	assign cfg.decay_factor = decay_q;
	assign cfg.stop_level   = stop_q;

	dsv_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.req_type     (s_tuser),
		.note         (s_tdata[6:0]),
		.velocity     (s_tdata[13:7]),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.sample       (m_tdata),
		.voice_active (m_tuser)
	);

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_TICK |=> !s_tready)
		else $error("tick request did not occupy the voice");

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared without a tick in progress");

	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == 16'h0000)
		else $error("silent voice produced a nonzero sample");

endmodule

@@ sim/tb_decaying_sine_voice.sv @@
`timescale 1ns / 100ps

module tb_decaying_sine_voice;
	import dsv_pkg::*;

	localparam int          CYCLE_LIMIT     = 600000;
	localparam int          SETTLE_CYCLES   = 16;
	localparam int          PHASE_ITEMS     = 132;
	localparam logic [63:0] RIGHT_ANGLE_Q30 = 64'd1686629713;
	localparam logic [63:0] UNIT_Q30        = 64'd1 << 30;
	localparam logic [63:0] TAYLOR_DIV [5]  = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

	// notes 120..131, Q16.16 Hz
	localparam logic [31:0] TONE_Q16 [12] = '{
		32'd548668578, 32'd581294109, 32'd615859655, 32'd652480576,
		32'd691279090, 32'd732384684, 32'd775934544, 32'd822074013,
		32'd870957077, 32'd922746880, 32'd977616265, 32'd1035748353
	};

	typedef struct packed {
		req_t       kind;
		logic [6:0] note;
		logic [6:0] vel;
	} voice_req_t;

	typedef struct packed {
		logic [15:0] sample;
		logic        active;
	} voice_out_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [15:0]         s_tdata = '0;  // note[6:0], velocity[13:7], zero pad
	logic [1:0]          s_tuser = REQ_TICK;  // req_type[1:0]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [15:0]         m_tdata;  // sample[15:0]
	logic                m_tuser;  // voice_active
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	decaying_sine_voice dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #2 clk = ~clk;

	voice_req_t  req_queue [$];
	voice_out_t  sample_queue [$];
	voice_req_t  req_in_flight;
	voice_out_t  want;
	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	bit          send_calm = 1'b0;
	bit          recv_calm = 1'b0;
	int unsigned mismatches = 0;
	int unsigned outputs_seen = 0;
	int unsigned cycles = 0;

	// voice state mirror
	logic [15:0]           decay_cfg = DECAY_RESET;
	logic [15:0]           stop_cfg = STOP_RESET;
	logic [PHASE_BITS-1:0] v_phase = '0;
	logic [PHASE_BITS-1:0] v_step = '0;
	logic [15:0]           v_level = '0;
	logic [15:0]           v_env = '0;
	logic                  v_on = 1'b0;

	function automatic int unsigned idle_len();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			return 0;
		end
		if (pick < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [PHASE_BITS-1:0] note_step(logic [6:0] n);
		logic [63:0] num;
		logic [63:0] den;
		int          oct;
		oct = n / 12;
		num = 64'(TONE_Q16[n % 12]) << PHASE_BITS;
		den = (64'(SAMPLE_RATE) << 16) << (10 - oct);
		return PHASE_BITS'((num + den / 2) / den);
	endfunction

	// {negative, magnitude q1.15}
	function automatic logic [16:0] table_sine(logic [SINE_TABLE_BITS-1:0] idx);
		logic [63:0] q;
		logic [63:0] th;
		logic [63:0] t2;
		logic [63:0] s;
		logic [63:0] v;
		logic [1:0]  quad;
		int          k;
		quad = idx[SINE_TABLE_BITS-1 -: 2];
		q = 64'(idx[SINE_TABLE_BITS-3:0]);
		if (quad[0]) begin
			q = (64'd1 << (SINE_TABLE_BITS - 2)) - q;
		end
		th = (q * RIGHT_ANGLE_Q30) >> (SINE_TABLE_BITS - 2);
		t2 = (th * th) >> 30;
		s = UNIT_Q30;
		for (k = 0; k < 5; k++) begin
			s = UNIT_Q30 - ((t2 * s) >> 30) / TAYLOR_DIV[k];
		end
		v = (th * s) >> 30;
		v = (v + (64'd1 << 14)) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return {quad[1], v[15:0]};
	endfunction

	task automatic advance_voice(input voice_req_t rq);
		voice_out_t  res;
		logic [16:0] sn;
		logic [63:0] prod;
		logic [63:0] rnd;
		logic [63:0] grown;
		case (rq.kind)
			REQ_NOTE_ON: begin
				v_phase = '0;
				v_level = 16'((32'(rq.vel) * 32'd49152 + 32'd63) / 32'd127);
				v_env = 16'd32768;
				v_step = note_step(rq.note);
				v_on = 1'b1;
			end
			REQ_NOTE_OFF: begin
			end
			REQ_NOTE_CUT: begin
				v_on = 1'b0;
				v_step = '0;
			end
			default: begin
				res = '0;
				if (v_on) begin
					sn = table_sine(v_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]);
					prod = 64'(sn[15:0]) * 64'(v_level) * 64'(v_env);
					rnd = (prod + (64'd1 << 30)) >> 31;
					if (sn[16]) begin
						if (rnd > 64'd32768) begin
							rnd = 64'd32768;
						end
						res.sample = 16'(64'h10000 - rnd);
					end else begin
						if (rnd > 64'd32767) begin
							rnd = 64'd32767;
						end
						res.sample = rnd[15:0];
					end
					res.active = 1'b1;
					v_phase = v_phase + v_step;
					grown = (64'(v_env) * 64'(decay_cfg)) >> 15;
					if (grown > 64'hFFFF) begin
						grown = 64'hFFFF;
					end
					v_env = grown[15:0];
					if (v_env <= stop_cfg) begin
						v_on = 1'b0;
						v_step = '0;
					end
				end
				sample_queue = {sample_queue, res};
			end
		endcase
	endtask

	function automatic voice_req_t rand_req();
		voice_req_t  rq;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 9) begin
			rq.kind = REQ_NOTE_ON;
		end else if (pick < 13) begin
			rq.kind = REQ_NOTE_OFF;
		end else if (pick < 17) begin
			rq.kind = REQ_NOTE_CUT;
		end else begin
			rq.kind = REQ_TICK;
		end
		rq.note = 7'($urandom);
		rq.vel = 7'($urandom);
		return rq;
	endfunction

	task automatic push_req(input req_t kind, input logic [6:0] note, input logic [6:0] vel);
		voice_req_t rq;
		rq.kind = kind;
		rq.note = note;
		rq.vel = vel;
		req_queue = {req_queue, rq};
	endtask

	task automatic push_ticks(input int n);
		repeat (n) push_req(REQ_TICK, 7'($urandom), 7'($urandom));
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (req_queue.size() != 0 || s_tvalid || sample_queue.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_t idx, input logic [15:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_DECAY) begin
			decay_cfg = val;
		end else begin
			stop_cfg = val;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				advance_voice(req_in_flight);
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (req_queue.size() != 0) begin
					req_in_flight = req_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {2'b00, req_in_flight.vel, req_in_flight.note};
					s_tuser <= req_in_flight.kind;
					if ($urandom_range(0, 63) == 0) begin
						send_calm = !send_calm;
					end
					send_gap = send_calm ? 0 : idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// sample monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				outputs_seen++;
				if (sample_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("output %0d: none expected, got sample %0d active %b",
							outputs_seen, $signed(m_tdata), m_tuser);
					end
				end else begin
					want = sample_queue.pop_front();
					if (want.sample !== m_tdata || want.active !== m_tuser) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("output %0d: expected sample %0d active %b, got %0d active %b",
								outputs_seen, $signed(want.sample), want.active,
								$signed(m_tdata), m_tuser);
						end
					end
				end
			end
			if (recv_stall != 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 127) == 0) begin
					recv_calm = !recv_calm;
				end
				if (!recv_calm) begin
					recv_stall = idle_len();
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [15:0] decay_set [7];
		logic [15:0] stop_set [7];
		decay_set = '{16'd30000, 16'd0, 16'd32768, 16'd65535, 16'd31000, 16'd0, 16'd32440};
		stop_set = '{16'd1000, 16'd0, 16'd0, 16'd32768, 16'd32768, 16'd0, 16'd164};
		decay_set[5] = 16'($urandom_range(28000, 32767));
		stop_set[5] = 16'($urandom_range(0, 3000));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// silent voice, then level and note extremes, restarts and cuts
		push_ticks(1);
		push_req(REQ_NOTE_OFF, 7'($urandom), 7'($urandom));
		push_req(REQ_NOTE_CUT, 7'($urandom), 7'($urandom));
		push_ticks(1);
		push_req(REQ_NOTE_ON, 7'd0, 7'd0);
		push_ticks(2);
		push_req(REQ_NOTE_ON, 7'd127, 7'd127);
		push_ticks(3);
		push_req(REQ_NOTE_OFF, 7'd127, 7'd127);
		push_ticks(1);
		push_req(REQ_NOTE_ON, 7'd69, 7'd64);
		push_ticks(2);
		push_req(REQ_NOTE_ON, 7'd85, 7'd1);
		push_ticks(1);
		push_req(REQ_NOTE_CUT, 7'd0, 7'd0);
		push_ticks(2);
		push_req(REQ_NOTE_ON, 7'd42, 7'd85);
		push_ticks(2);

		for (int p = 0; p < 7; p++) begin
			wait_idle();
			write_reg(REG_DECAY, decay_set[p]);
			write_reg(REG_STOP, stop_set[p]);
			// start each setting with a fresh note so the envelope path is exercised
			push_req(REQ_NOTE_ON, 7'($urandom), 7'($urandom));
			repeat (PHASE_ITEMS) req_queue = {req_queue, rand_req()};
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
